// File: src/vrac_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the checksum helper for the VRRPv3 advertisement checker.
// No dependencies; used by vrac_parser, vrac_emitter and vrrp_advert_receive_checker.

package vrac_pkg;

    localparam logic [10:0] COUNT_MAX    = 11'd2047;
    localparam logic [10:0] HDR_LEN      = 11'd8;
    localparam logic [7:0]  VT_ADVERT_V3 = 8'h31;
    localparam logic [15:0] PROTO_VRRP   = 16'd112;
    localparam logic [15:0] CSUM_GOOD    = 16'hffff;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_VT    = 3'd2,
        ST_TOO_MANY  = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_BAD_CSUM  = 3'd5
    } status_t;

    typedef enum logic {
        KIND_SUMMARY = 1'b0,
        KIND_ADDRESS = 1'b1
    } kind_t;

    // Handoff from the parser to the emitter at the end of a message.
    typedef struct packed {
        logic        start;
        status_t     status;
        logic [7:0]  router;
        logic [7:0]  priority_level;
        logic [11:0] interval;
        logic [7:0]  count;
        logic [31:0] sender;
    } msg_info_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [7:0]  router_id;
        logic [7:0]  priority_level;
        logic [11:0] advert_interval;
        logic [4:0]  address_count;
        logic [31:0] virtual_address;
        logic [31:0] sender;
        logic        run_end;
    } result_t;

    // Ones-complement 16-bit add with end-around carry.
    function automatic logic [15:0] ones_add16(input logic [15:0] s, input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// File: src/vrac_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module vrac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/vrac_parser.sv
`timescale 1ns / 1ps
// Byte parser: header capture, running checksum, address assembly and final status.
// Depends on vrac_pkg; writes virtual addresses into the address RAM.

module vrac_parser #(
    parameter int MAX_ADDRESSES = 16,
    localparam int AW = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic [31:0]         in_src,
    input  logic [31:0]         in_dst,
    input  logic                emit_busy,
    output logic                ram_we,
    output logic [AW-1:0]       ram_waddr,
    output logic [31:0]         ram_wdata,
    output vrac_pkg::msg_info_t info
);

    localparam logic [10:0] POS_VER_TYPE = 11'd0;
    localparam logic [10:0] POS_ROUTER   = 11'd1;
    localparam logic [10:0] POS_PRIORITY = 11'd2;
    localparam logic [10:0] POS_COUNT    = 11'd3;
    localparam logic [10:0] POS_INT_HI   = 11'd4;
    localparam logic [10:0] POS_INT_LO   = 11'd5;

    logic [10:0] byte_cnt_reg;
    logic [15:0] csum_reg;
    logic [7:0]  high_reg;
    logic [23:0] build_reg;
    logic        finish_reg;
    logic [7:0]  vt_reg;
    logic [7:0]  router_reg;
    logic [7:0]  prio_reg;
    logic [7:0]  count_reg;
    logic [11:0] interval_reg;
    logic [31:0] sender_reg;

    logic        accept;
    logic [10:0] pos;
    logic [18:0] pseudo_wide;
    logic [16:0] pseudo_f1;
    logic [15:0] pseudo;
    logic [7:0]  count_eff;
    logic [10:0] msg_len_eff;
    logic        in_range;
    logic        in_body;
    logic [10:0] off;
    logic [8:0]  slot;
    logic [15:0] csum_c0;
    logic [15:0] csum_c1;
    logic [15:0] csum_next;
    logic [10:0] byte_cnt_next;
    logic [10:0] msg_len_reg;
    vrac_pkg::status_t status;

    assign in_ready = !finish_reg && !emit_busy;
    assign accept   = in_valid && in_ready;
    assign pos      = byte_cnt_reg;

    // Pseudo-header: source, destination and protocol, folded to 16 bits with end-around carry.
    assign pseudo_wide = 19'(in_src[31:16]) + 19'(in_src[15:0]) + 19'(in_dst[31:16])
                       + 19'(in_dst[15:0]) + 19'(vrac_pkg::PROTO_VRRP);
    assign pseudo_f1   = 17'(pseudo_wide[15:0]) + 17'(pseudo_wide[18:16]);
    assign pseudo      = pseudo_f1[15:0] + 16'(pseudo_f1[16]);

    assign count_eff   = (pos == POS_COUNT) ? in_byte : count_reg;
    assign msg_len_eff = vrac_pkg::HDR_LEN + {1'b0, count_eff, 2'b00};
    assign in_range    = (pos < 11'd4) || (pos < msg_len_eff);
    assign in_body     = in_range && (pos >= vrac_pkg::HDR_LEN);
    assign off         = pos - vrac_pkg::HDR_LEN;
    assign slot        = off[10:2];

    always_comb begin
        csum_c0 = (pos == POS_VER_TYPE) ? pseudo : csum_reg;
        csum_c1 = (pos == POS_COUNT)
                ? vrac_pkg::ones_add16(csum_c0,
                                       16'(vrac_pkg::HDR_LEN + {1'b0, in_byte, 2'b00}))
                : csum_c0;
        csum_next = (in_range && pos[0]) ? vrac_pkg::ones_add16(csum_c1, {high_reg, in_byte})
                                         : csum_c1;
    end

    assign byte_cnt_next = (pos < vrac_pkg::COUNT_MAX) ? pos + 11'd1 : vrac_pkg::COUNT_MAX;

    assign ram_we    = accept && in_body && (off[1:0] == 2'b11)
                       && (slot < 9'(MAX_ADDRESSES));
    assign ram_waddr = slot[AW-1:0];
    assign ram_wdata = {build_reg, in_byte};

    // Status is judged in the cycle after the last byte is taken, from the settled registers.
    assign msg_len_reg = vrac_pkg::HDR_LEN + {1'b0, count_reg, 2'b00};

    always_comb begin
        if (byte_cnt_reg < vrac_pkg::HDR_LEN) begin
            status = vrac_pkg::ST_SHORT;
        end else if (vt_reg != vrac_pkg::VT_ADVERT_V3) begin
            status = vrac_pkg::ST_BAD_VT;
        end else if (count_reg > 8'(MAX_ADDRESSES)) begin
            status = vrac_pkg::ST_TOO_MANY;
        end else if (byte_cnt_reg < msg_len_reg) begin
            status = vrac_pkg::ST_TRUNCATED;
        end else if (csum_reg != vrac_pkg::CSUM_GOOD) begin
            status = vrac_pkg::ST_BAD_CSUM;
        end else begin
            status = vrac_pkg::ST_OK;
        end
    end

    assign info.start          = finish_reg;
    assign info.status         = status;
    assign info.router         = router_reg;
    assign info.priority_level = prio_reg;
    assign info.interval       = interval_reg;
    assign info.count          = count_reg;
    assign info.sender         = sender_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg <= '0;
            csum_reg     <= '0;
            high_reg     <= '0;
            build_reg    <= '0;
            finish_reg   <= 1'b0;
            vt_reg       <= '0;
            router_reg   <= '0;
            prio_reg     <= '0;
            count_reg    <= '0;
            interval_reg <= '0;
            sender_reg   <= '0;
        end else begin
            finish_reg <= accept && in_last;
            if (finish_reg) begin
                byte_cnt_reg <= '0;
                csum_reg     <= '0;
                high_reg     <= '0;
                build_reg    <= '0;
            end else if (accept) begin
                byte_cnt_reg <= byte_cnt_next;
                csum_reg     <= csum_next;
                if (in_range && !pos[0]) begin
                    high_reg <= in_byte;
                end
                if (in_body) begin
                    build_reg <= (off[1:0] == 2'b11) ? 24'd0 : {build_reg[15:0], in_byte};
                end
                case (pos)
                    POS_VER_TYPE: begin
                        vt_reg     <= in_byte;
                        sender_reg <= in_src;
                    end
                    POS_ROUTER:   router_reg          <= in_byte;
                    POS_PRIORITY: prio_reg            <= in_byte;
                    POS_COUNT:    count_reg           <= in_byte;
                    POS_INT_HI:   interval_reg        <= {in_byte[3:0], 8'd0};
                    POS_INT_LO:   interval_reg[7:0]   <= in_byte;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: src/vrac_emitter.sv
`timescale 1ns / 1ps
// Result emitter: summary, then one result per stored address if ok, behind an output register.
// Depends on vrac_pkg; reads the address RAM, whose read data is registered.

module vrac_emitter #(
    parameter int MAX_ADDRESSES = 16,
    localparam int AW = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  vrac_pkg::msg_info_t info,
    output logic                busy,
    output logic                ram_re,
    output logic [AW-1:0]       ram_raddr,
    input  logic [31:0]         ram_rdata,
    output logic                out_valid,
    input  logic                out_ready,
    output vrac_pkg::result_t   out_result
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_SUMMARY,
        E_READ,
        E_ADDR
    } emit_state_t;

    emit_state_t         state_reg;
    logic                valid_reg;
    vrac_pkg::result_t   result_reg;
    vrac_pkg::msg_info_t info_reg;
    logic [AW-1:0]       idx_reg;

    logic take;
    logic more;
    logic last_addr;

    assign take      = valid_reg && out_ready;
    assign more      = (info_reg.status == vrac_pkg::ST_OK) && (info_reg.count != 8'd0);
    assign last_addr = (8'(idx_reg) + 8'd1) == info_reg.count;

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            E_SUMMARY: begin
                ram_re = take && more;
            end
            E_ADDR: begin
                ram_re    = take && !last_addr;
                ram_raddr = idx_reg + AW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                E_IDLE: begin
                    if (info.start) begin
                        info_reg                   <= info;
                        result_reg.kind            <= vrac_pkg::KIND_SUMMARY;
                        result_reg.status          <= info.status;
                        result_reg.virtual_address <= '0;
                        result_reg.sender          <= info.sender;
                        if (info.status == vrac_pkg::ST_OK) begin
                            result_reg.router_id       <= info.router;
                            result_reg.priority_level  <= info.priority_level;
                            result_reg.advert_interval <= info.interval;
                            result_reg.address_count   <= info.count[4:0];
                            result_reg.run_end         <= (info.count == 8'd0);
                        end else begin
                            result_reg.router_id       <= '0;
                            result_reg.priority_level  <= '0;
                            result_reg.advert_interval <= '0;
                            result_reg.address_count   <= '0;
                            result_reg.run_end         <= 1'b1;
                        end
                        valid_reg <= 1'b1;
                        state_reg <= E_SUMMARY;
                    end
                end
                E_SUMMARY: begin
                    if (take) begin
                        valid_reg <= 1'b0;
                        if (more) begin
                            idx_reg   <= '0;
                            state_reg <= E_READ;
                        end else begin
                            state_reg <= E_IDLE;
                        end
                    end
                end
                E_READ: begin
                    result_reg.kind            <= vrac_pkg::KIND_ADDRESS;
                    result_reg.virtual_address <= ram_rdata;
                    result_reg.run_end         <= last_addr;
                    valid_reg                  <= 1'b1;
                    state_reg                  <= E_ADDR;
                end
                E_ADDR: begin
                    if (take) begin
                        valid_reg <= 1'b0;
                        if (last_addr) begin
                            state_reg <= E_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= E_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= E_IDLE;
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign busy       = (state_reg != E_IDLE);
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// File: src/vrrp_advert_receive_checker.sv
`timescale 1ns / 1ps
// Top level of the VRRPv3 IPv4 advertisement receive checker.
// Depends on vrac_pkg, vrac_ram, vrac_parser and vrac_emitter.

// This block checks a received VRRPv3 IPv4 advertisement that arrives one byte per transfer,
// starting at the VRRP header, with tlast on the final byte. The sender and destination
// addresses are sampled with the first byte and enter the checksum as the IPv4 pseudo-header
// together with protocol 112 and the length 8 + 4 * count; only the first 8 + 4 * count bytes
// are summed and bytes after them are ignored. Message bytes are taken at one per clock cycle.
// After the last byte, tready goes low while the status is judged, then the summary
// transfer is offered; when the status is ok, one transfer per virtual address follows,
// each read first from the address RAM, which has a registered read. tready returns high
// once the last result of the message (marked by tlast) has been transferred. The virtual
// addresses are held in a RAM of MAX_ADDRESSES words that is written only while bytes are
// taken and read only while results are sent, so the two never meet. The byte counter
// saturates at 2047, and bytes beyond that count are ignored.

module vrrp_advert_receive_checker #(
    parameter int MAX_ADDRESSES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: data_byte[7:0], sender_address[39:8], dest_address[71:40]
    input  logic [71:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: status[2:0], router_id[10:3], priority_level[18:11],
    // advert_interval[30:19], address_count[35:31], virtual_address[67:36],
    // sender[99:68], zero fill[103:100]
    output logic [103:0] m_axis_tdata,
    // tuser: result_kind (0 summary, 1 virtual address)
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int AW = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [31:0]         ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [31:0]         ram_rdata;
    logic                emit_busy;
    vrac_pkg::msg_info_t info;
    vrac_pkg::result_t   result;

    vrac_parser #(
        .MAX_ADDRESSES(MAX_ADDRESSES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata[7:0]),
        .in_last   (s_axis_tlast),
        .in_src    (s_axis_tdata[39:8]),
        .in_dst    (s_axis_tdata[71:40]),
        .emit_busy (emit_busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .info      (info)
    );

    vrac_ram #(
        .WIDTH(32),
        .DEPTH(MAX_ADDRESSES)
    ) u_addr_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vrac_emitter #(
        .MAX_ADDRESSES(MAX_ADDRESSES)
    ) u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .info       (info),
        .busy       (emit_busy),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the result fields into the master-side transfer.
    assign m_axis_tdata = {4'd0, result.sender, result.virtual_address, result.address_count,
                           result.advert_interval, result.priority_level, result.router_id,
                           result.status};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.run_end;

`ifndef ASSERT_OFF
    // The address RAM is never written and read in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) !(ram_we && ram_re))
        else $error("address RAM written and read in the same cycle");

    // The cycle after the last byte is taken, no further byte may be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("byte accepted while the previous message is being judged");

    // A failed summary is always the only result of its message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == vrac_pkg::KIND_SUMMARY)
         && (m_axis_tdata[2:0] != vrac_pkg::ST_OK)) |-> m_axis_tlast)
        else $error("failed summary without tlast");

    // Address results only follow an ok summary.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == vrac_pkg::KIND_ADDRESS))
        |-> (m_axis_tdata[2:0] == vrac_pkg::ST_OK))
        else $error("address result with a failing status");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the VRRPv3 advertisement receive checker: byte streams
// with random handshake gaps, results compared against a cycle-free software parser.
// Depends on vrac_pkg and the RTL top vrrp_advert_receive_checker with its submodules.

module tb;

    localparam int MAX_ADDRS    = 16;
    // One long receiver hold-off, placed after this many result transfers.
    localparam int HOLD_AT      = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 80;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PRINT_CAP    = 50;

    // How the header and address bytes of a message are filled.
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    // One message of the stimulus table. Rows with typed set carry their failure
    // status right in the table; all others are judged by the parser model below.
    typedef struct {
        logic [7:0]        vt;
        logic [7:0]        count;
        int                length;
        fill_t             fill;
        bit                corrupt;
        logic [31:0]       src;
        logic [31:0]       dst;
        bit                typed;
        vrac_pkg::status_t want;
    } msg_row_t;

    logic         aclk;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata from bit 0: data_byte[7:0], sender_address[39:8], dest_address[71:40]
    logic [71:0]  s_axis_tdata  = '0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata from bit 0: status[2:0], router_id[10:3], priority_level[18:11],
    // advert_interval[30:19], address_count[35:31], virtual_address[67:36],
    // sender[99:68], zero fill[103:100]
    logic [103:0] m_axis_tdata;
    // tuser: result_kind
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    vrrp_advert_receive_checker #(
        .MAX_ADDRESSES(MAX_ADDRS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Parser model state; it mirrors the block's registers after reset.
    logic [10:0] rx_pos      = '0;
    logic [15:0] rx_sum      = '0;
    logic [7:0]  rx_high     = '0;
    logic [7:0]  rx_vt       = '0;
    logic [7:0]  rx_router   = '0;
    logic [7:0]  rx_prio     = '0;
    logic [7:0]  rx_count    = '0;
    logic [15:0] rx_interval = '0;
    logic [31:0] rx_sender   = '0;
    logic [23:0] rx_build    = '0;
    logic [31:0] rx_addr [MAX_ADDRS];

    vrac_pkg::result_t parsed_results [$];
    vrac_pkg::result_t want_result;

    int error_count     = 0;
    int bytes_sent      = 0;
    int messages_sent   = 0;
    int results_checked = 0;
    int address_results = 0;
    int status_seen [8] = '{default: 0};

    // Ones-complement 16-bit addition with the carry folded back in.
    function automatic logic [15:0] ones_sum16(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] wide;
        wide = {1'b0, acc} + {1'b0, word};
        return wide[16] ? wide[15:0] + 16'd1 : wide[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_CAP)
            $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        error_count++;
    endtask

    // Advances the parser model by one accepted byte. On the last byte of a
    // message it queues the results that the block must produce.
    task automatic parse_advert_byte(input logic [7:0] b, input logic last,
                                     input logic [31:0] src, input logic [31:0] dst,
                                     input bit typed, input vrac_pkg::status_t want,
                                     input logic [31:0] typed_sender);
        int                pos;
        int                msg_len;
        int                offset;
        vrac_pkg::status_t verdict;
        vrac_pkg::result_t r;
        pos = int'(rx_pos);
        if (pos == 0) begin
            // The pseudo-header enters the sum with the first byte.
            rx_sender = src;
            rx_sum = '0;
            rx_sum = ones_sum16(rx_sum, src[31:16]);
            rx_sum = ones_sum16(rx_sum, src[15:0]);
            rx_sum = ones_sum16(rx_sum, dst[31:16]);
            rx_sum = ones_sum16(rx_sum, dst[15:0]);
            rx_sum = ones_sum16(rx_sum, vrac_pkg::PROTO_VRRP);
        end
        case (pos)
            0: rx_vt = b;
            1: rx_router = b;
            2: rx_prio = b;
            3: begin
                rx_count = b;
                rx_sum = ones_sum16(rx_sum, 16'(int'(vrac_pkg::HDR_LEN) + 4 * int'(b)));
            end
            4: rx_interval = {b, 8'h00};
            5: rx_interval[7:0] = b;
            default: ;
        endcase
        msg_len = int'(vrac_pkg::HDR_LEN) + 4 * int'(rx_count);
        // Only the header and the announced addresses are summed and stored.
        if (pos < 4 || pos < msg_len) begin
            if (pos % 2 == 0)
                rx_high = b;
            else
                rx_sum = ones_sum16(rx_sum, {rx_high, b});
            if (pos >= int'(vrac_pkg::HDR_LEN)) begin
                offset = pos - int'(vrac_pkg::HDR_LEN);
                if (offset % 4 == 3) begin
                    if (offset / 4 < MAX_ADDRS)
                        rx_addr[offset / 4] = {rx_build, b};
                    rx_build = '0;
                end else begin
                    rx_build = {rx_build[15:0], b};
                end
            end
        end
        rx_pos = (rx_pos < vrac_pkg::COUNT_MAX) ? rx_pos + 11'd1 : vrac_pkg::COUNT_MAX;
        if (last) begin
            // The checks are ranked; the first one that fails names the status.
            if (rx_pos < vrac_pkg::HDR_LEN)
                verdict = vrac_pkg::ST_SHORT;
            else if (rx_vt != vrac_pkg::VT_ADVERT_V3)
                verdict = vrac_pkg::ST_BAD_VT;
            else if (int'(rx_count) > MAX_ADDRS)
                verdict = vrac_pkg::ST_TOO_MANY;
            else if (int'(rx_pos) < msg_len)
                verdict = vrac_pkg::ST_TRUNCATED;
            else if (rx_sum != vrac_pkg::CSUM_GOOD)
                verdict = vrac_pkg::ST_BAD_CSUM;
            else
                verdict = vrac_pkg::ST_OK;
            r = '0;
            r.kind = vrac_pkg::KIND_SUMMARY;
            r.sender = rx_sender;
            r.run_end = 1'b1;
            if (typed) begin
                // Table rows with a typed status take that verdict as written.
                r.status = want;
                r.sender = typed_sender;
                parsed_results.push_back(r);
            end else if (verdict != vrac_pkg::ST_OK) begin
                // A failed message reports only its status and sender.
                r.status = verdict;
                parsed_results.push_back(r);
            end else begin
                r.status = vrac_pkg::ST_OK;
                r.router_id = rx_router;
                r.priority_level = rx_prio;
                r.advert_interval = rx_interval[11:0];
                r.address_count = rx_count[4:0];
                r.run_end = (rx_count == 8'd0);
                parsed_results.push_back(r);
                r.kind = vrac_pkg::KIND_ADDRESS;
                for (int i = 0; i < int'(rx_count) && i < MAX_ADDRS; i++) begin
                    r.virtual_address = rx_addr[i];
                    r.run_end = (i + 1 == int'(rx_count));
                    parsed_results.push_back(r);
                end
            end
            rx_pos = '0;
            rx_sum = '0;
            rx_high = '0;
            rx_build = '0;
        end
    endtask

    // Offers one byte, waits for its transfer, then feeds it to the parser model.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [31:0] src, input logic [31:0] dst,
                             input bit quiet, input msg_row_t row);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dst, src, b};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
        parse_advert_byte(b, last, src, dst, row.typed, row.want, row.src);
    endtask

    function automatic logic [7:0] fill_byte(input fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hff;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Builds the message bytes of one row, with a checksum that makes the sum
    // come out right unless the row asks for a corrupted one, and sends them.
    task automatic send_message(input msg_row_t row);
        logic [7:0]  body [$];
        logic [15:0] sum;
        int          span;
        bit          quiet;
        body = {};
        for (int i = 0; i < row.length; i++)
            body.push_back(fill_byte(row.fill));
        body[0] = row.vt;
        if (row.length > 3)
            body[3] = row.count;
        if (row.length > 7) begin
            body[6] = 8'h00;
            body[7] = 8'h00;
        end
        span = int'(vrac_pkg::HDR_LEN) + 4 * int'(row.count);
        if (span > row.length)
            span = row.length;
        sum = ones_sum16(16'h0000, row.src[31:16]);
        sum = ones_sum16(sum, row.src[15:0]);
        sum = ones_sum16(sum, row.dst[31:16]);
        sum = ones_sum16(sum, row.dst[15:0]);
        sum = ones_sum16(sum, vrac_pkg::PROTO_VRRP);
        sum = ones_sum16(sum, 16'(int'(vrac_pkg::HDR_LEN) + 4 * int'(row.count)));
        for (int i = 0; i < span; i += 2)
            sum = ones_sum16(sum, {body[i], (i + 1 < span) ? body[i + 1] : 8'h00});
        if (row.length > 7) begin
            body[6] = ~sum[15:8];
            body[7] = ~sum[7:0] ^ {7'd0, row.corrupt};
        end
        // About a quarter of the messages go out back to back.
        quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < row.length; i++)
            send_byte(body[i], i == row.length - 1,
                      (i == 0) ? row.src : $urandom, (i == 0) ? row.dst : $urandom,
                      quiet, row);
        messages_sent++;
    endtask

    function automatic msg_row_t mk_row(input logic [7:0] vt, input logic [7:0] count,
                                        input int length, input fill_t fill,
                                        input bit corrupt, input logic [31:0] src,
                                        input logic [31:0] dst, input bit typed,
                                        input vrac_pkg::status_t want);
        msg_row_t r;
        r.vt = vt;
        r.count = count;
        r.length = length;
        r.fill = fill;
        r.corrupt = corrupt;
        r.src = src;
        r.dst = dst;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    // Mostly well-formed advertisements with random content; the rest is bad
    // checksums, truncated, short, wrong version/type and oversized counts.
    function automatic msg_row_t random_message();
        msg_row_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        r = mk_row(vrac_pkg::VT_ADVERT_V3, 8'd0, 0, FILL_RANDOM, 1'b0, $urandom, $urandom,
                   1'b0, vrac_pkg::ST_OK);
        if ($urandom_range(0, 9) == 0)
            r.count = 8'($urandom_range(5, MAX_ADDRS));
        else
            r.count = 8'($urandom_range(0, 4));
        r.length = int'(vrac_pkg::HDR_LEN) + 4 * int'(r.count);
        if ($urandom_range(0, 3) == 0)
            r.length += $urandom_range(1, 6);
        if (pick >= 70 && pick < 80) begin
            r.corrupt = 1'b1;
        end else if (pick >= 80 && pick < 86) begin
            if (r.count == 8'd0)
                r.count = 8'd1;
            r.length = $urandom_range(int'(vrac_pkg::HDR_LEN),
                                      int'(vrac_pkg::HDR_LEN) + 4 * int'(r.count) - 1);
        end else if (pick >= 86 && pick < 90) begin
            r.length = $urandom_range(1, int'(vrac_pkg::HDR_LEN) - 1);
        end else if (pick >= 90 && pick < 95) begin
            r.vt = 8'($urandom_range(0, 255));
            if (r.vt == vrac_pkg::VT_ADVERT_V3)
                r.vt ^= 8'h10;
        end else if (pick >= 95) begin
            r.count = 8'($urandom_range(MAX_ADDRS + 1, 255));
            r.length = $urandom_range(int'(vrac_pkg::HDR_LEN), 40);
        end
        return r;
    endfunction

    // Result checker: every transfer on the result side is matched against the
    // oldest expectation, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_checked++;
            if (parsed_results.size() == 0) begin
                report_mismatch("result with nothing expected (sender)",
                                m_axis_tdata[99:68], 32'd0);
            end else begin
                want_result = parsed_results.pop_front();
                if (want_result.kind == vrac_pkg::KIND_ADDRESS)
                    address_results++;
                else
                    status_seen[want_result.status]++;
                if (m_axis_tuser !== want_result.kind)
                    report_mismatch("result_kind", 32'(m_axis_tuser), 32'(want_result.kind));
                if (m_axis_tdata[2:0] !== want_result.status)
                    report_mismatch("status", 32'(m_axis_tdata[2:0]), 32'(want_result.status));
                if (m_axis_tdata[10:3] !== want_result.router_id)
                    report_mismatch("router_id", 32'(m_axis_tdata[10:3]),
                                    32'(want_result.router_id));
                if (m_axis_tdata[18:11] !== want_result.priority_level)
                    report_mismatch("priority_level", 32'(m_axis_tdata[18:11]),
                                    32'(want_result.priority_level));
                if (m_axis_tdata[30:19] !== want_result.advert_interval)
                    report_mismatch("advert_interval", 32'(m_axis_tdata[30:19]),
                                    32'(want_result.advert_interval));
                if (m_axis_tdata[35:31] !== want_result.address_count)
                    report_mismatch("address_count", 32'(m_axis_tdata[35:31]),
                                    32'(want_result.address_count));
                if (m_axis_tdata[67:36] !== want_result.virtual_address)
                    report_mismatch("virtual_address", m_axis_tdata[67:36],
                                    want_result.virtual_address);
                if (m_axis_tdata[99:68] !== want_result.sender)
                    report_mismatch("sender", m_axis_tdata[99:68], want_result.sender);
                if (m_axis_tlast !== want_result.run_end)
                    report_mismatch("run_end", 32'(m_axis_tlast), 32'(want_result.run_end));
                if (m_axis_tdata[103:100] !== 4'd0)
                    report_mismatch("tdata zero fill", 32'(m_axis_tdata[103:100]), 32'd0);
            end
        end
    end

    // Result sink: random ready gaps, stretches without gaps, and one long
    // hold-off while the sender keeps offering bytes.
    initial begin : result_sink
        int gap;
        int handshakes;
        bit quiet;
        bit held;
        handshakes = 0;
        quiet = 1'b0;
        held = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (handshakes % 16 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            gap = quiet ? 0 : $urandom_range(0, 10);
            if (!held && handshakes == HOLD_AT) begin
                gap = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            handshakes++;
        end
    end

    // Main sequence: reset, directed table, random messages, drain, verdict.
    initial begin : stimulus
        msg_row_t directed_rows [$];
        int       random_start;
        int       drain;
        for (int i = 0; i < MAX_ADDRS; i++)
            rx_addr[i] = '0;

        // vt, count, length, fill, corrupt checksum, sender, destination, typed, status
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd0, 1, FILL_RANDOM, 1'b0,
            32'h0a00_0001, 32'he000_0012, 1'b1, vrac_pkg::ST_SHORT));
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd0, 7, FILL_RANDOM, 1'b0,
            32'h0a00_0002, 32'he000_0012, 1'b1, vrac_pkg::ST_SHORT));
        // A short message is short even with a bad version and a huge count.
        directed_rows.push_back(mk_row(8'h00, 8'd20, 5, FILL_RANDOM, 1'b0,
            32'h0a00_0003, 32'he000_0012, 1'b1, vrac_pkg::ST_SHORT));
        directed_rows.push_back(mk_row(8'h21, 8'd0, 8, FILL_RANDOM, 1'b0,
            32'h0a00_0004, 32'he000_0012, 1'b1, vrac_pkg::ST_BAD_VT));
        directed_rows.push_back(mk_row(8'h32, 8'd0, 8, FILL_RANDOM, 1'b0,
            32'h0a00_0005, 32'he000_0012, 1'b1, vrac_pkg::ST_BAD_VT));
        // A bad version/type outranks too many addresses.
        directed_rows.push_back(mk_row(8'hff, 8'd40, 12, FILL_RANDOM, 1'b0,
            32'h0a00_0006, 32'he000_0012, 1'b1, vrac_pkg::ST_BAD_VT));
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd17, 8, FILL_RANDOM, 1'b0,
            32'h0a00_0007, 32'he000_0012, 1'b1, vrac_pkg::ST_TOO_MANY));
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd255, 20, FILL_RANDOM, 1'b0,
            32'h0a00_0008, 32'he000_0012, 1'b1, vrac_pkg::ST_TOO_MANY));
        // Truncation outranks a bad checksum.
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd3, 12, FILL_RANDOM, 1'b1,
            32'h0a00_0009, 32'he000_0012, 1'b1, vrac_pkg::ST_TRUNCATED));
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd16, 71, FILL_RANDOM, 1'b0,
            32'h0a00_000a, 32'he000_0012, 1'b1, vrac_pkg::ST_TRUNCATED));
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd0, 8, FILL_RANDOM, 1'b1,
            32'h0a00_000b, 32'he000_0012, 1'b1, vrac_pkg::ST_BAD_CSUM));
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd16, 72, FILL_RANDOM, 1'b1,
            32'h0a00_000c, 32'he000_0012, 1'b1, vrac_pkg::ST_BAD_CSUM));
        // Field extremes: all-zero and all-ones content, no addresses and the most.
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd0, 8, FILL_ZERO, 1'b0,
            32'h0000_0000, 32'h0000_0000, 1'b0, vrac_pkg::ST_OK));
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd16, 72, FILL_ONES, 1'b0,
            32'hffff_ffff, 32'hffff_ffff, 1'b0, vrac_pkg::ST_OK));
        // Trailing bytes after the address in the first row are left out of the checksum.
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd1, 17, FILL_RANDOM, 1'b0,
            32'hc0a8_0101, 32'he000_0012, 1'b0, vrac_pkg::ST_OK));
        directed_rows.push_back(mk_row(vrac_pkg::VT_ADVERT_V3, 8'd4, 24, FILL_RANDOM, 1'b0,
            32'hc0a8_0103, 32'he000_0012, 1'b0, vrac_pkg::ST_OK));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_message(directed_rows[i]);

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
            send_message(random_message());

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        drain = 0;
        while (parsed_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        if (parsed_results.size() != 0)
            report_mismatch("results still outstanding at the end",
                            parsed_results.size(), 32'd0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d advertisements in %0d byte transfers; %s",
                 messages_sent, bytes_sent, "every result was compared field by field.");
        $display("Checked %0d results, %0d addresses; ok %0d, short %0d, bad vt %0d,",
                 results_checked, address_results, status_seen[vrac_pkg::ST_OK],
                 status_seen[vrac_pkg::ST_SHORT], status_seen[vrac_pkg::ST_BAD_VT]);
        $display("too many %0d, truncated %0d, bad checksum %0d.",
                 status_seen[vrac_pkg::ST_TOO_MANY], status_seen[vrac_pkg::ST_TRUNCATED],
                 status_seen[vrac_pkg::ST_BAD_CSUM]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("Timeout: the run did not complete.");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
src/vrac_pkg.sv
src/vrac_ram.sv
src/vrac_parser.sv
src/vrac_emitter.sv
src/vrrp_advert_receive_checker.sv
sim/tb.sv
